[src/hgcd_pkg.sv]
package hgcd_pkg;

    // Fixed field widths
    localparam int LAT_W    = 28;
    localparam int LON_W    = 29;
    localparam int RADIUS_W = 24;
    localparam int DIST_W   = 26;

    localparam int DEFAULT_FRAC_BITS  = 30;
    localparam int DEFAULT_ITERATIONS = 32;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd6371000;

    localparam longint UDEG_TURN         = 64'sd360000000;
    localparam longint UDEG_HALF_TURN    = 64'sd180000000;
    localparam longint UDEG_QUARTER_TURN = 64'sd90000000;

    localparam logic [63:0] RAD_PER_UDEG_Q62 = 64'd80489105090;
    localparam logic [63:0] INV_GAIN_Q62     = 64'd2800459869029452956;
    localparam logic [63:0] QUARTER_PI_Q62   = 64'd3622009729038561421;
    localparam logic [63:0] DIST_MAX         = 64'd67108863;

    // Working width of CORDIC datapath: sign + 2 integer bits + fraction + guard
    function automatic int cordic_width(input int frac);
        return frac + 4;
    endfunction

    // Q2.62 value rounded half up to Q.frac
    function automatic logic [63:0] q62_to_f(input logic [63:0] v, input int frac);
        logic [63:0] r;
        r = (v + (64'd1 << (61 - frac))) >> (62 - frac);
        return r;
    endfunction

    // Unsigned quotient by shift and subtract, used only on constants
    function automatic logic [63:0] const_udiv(input logic [63:0] num,
                                               input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = 64'd0;
        r = 65'd0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= 65'(den)) begin
                r    = r - 65'(den);
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // arctan(2^-i) in Q.frac, from the truncated odd-power series in Q2.62
    function automatic logic [63:0] atan_entry(input int i, input int frac);
        logic [63:0] a;
        logic [63:0] term;
        int e;
        int k;
        a = 64'd0;
        if (i == 0) begin
            a = QUARTER_PI_Q62;
        end else begin
            k = 0;
            for (e = i; e <= 62; e += 2 * i) begin
                term = const_udiv(64'd1 << (62 - e), 64'(2 * k + 1));
                if (k[0]) begin
                    a = a - term;
                end else begin
                    a = a + term;
                end
                k++;
            end
        end
        return q62_to_f(a, frac);
    endfunction

    function automatic logic [63:0] inv_gain(input int frac);
        return q62_to_f(INV_GAIN_Q62, frac);
    endfunction

endpackage

[src/haversine_great_circle_distance.sv]
// Haversine great-circle distance, fully pipelined.
// Input channel s_*: two positions in signed microdegrees, valid/ready.
// Result channel m_*: distance in metres, rounded, saturated at 2^26-1.
// Throughput: one request per cycle while the pipeline is not stalled. Every
// stage is a row of cells (CORDIC rotation chains, square-root chains,
// vectoring chain) that all advance together. In order: wrap and fold,
// to radians, rotation, products, clamp, square root, vectoring, scale.
// The pipeline advances whenever the output register is empty or being
// taken; when the receiver stalls with m_valid high, the whole chain holds
// and s_ready drops. Reset clears all valid bits, holds s_ready low and
// loads the radius register with 6371000; payload registers are not reset.
// cfg_we/cfg_wdata write radius_reg; write only while idle.
module haversine_great_circle_distance #(
    parameter int ANGLE_FRAC_BITS   = hgcd_pkg::DEFAULT_FRAC_BITS,
    parameter int CORDIC_ITERATIONS = hgcd_pkg::DEFAULT_ITERATIONS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [hgcd_pkg::LAT_W-1:0]  s_lat_a,
    input  logic signed [hgcd_pkg::LON_W-1:0]  s_lon_a,
    input  logic signed [hgcd_pkg::LAT_W-1:0]  s_lat_b,
    input  logic signed [hgcd_pkg::LON_W-1:0]  s_lon_b,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [hgcd_pkg::DIST_W-1:0]        m_distance_m,
    input  logic                               cfg_we,
    input  logic [hgcd_pkg::RADIUS_W-1:0]      cfg_wdata
);
    localparam int F    = ANGLE_FRAC_BITS;
    localparam int N    = CORDIC_ITERATIONS;
    localparam int W    = F + 4;
    localparam int SRW  = F + 1;
    localparam int STW  = 2 * F + 1;
    localparam int LAT  = 2 + N + 3 + 1 + SRW + N + 2;
    localparam int UW   = 28;
    localparam int PW   = 2 * F + 2;

    logic [hgcd_pkg::RADIUS_W-1:0] radius_reg;
    logic [LAT-1:0] vld_reg;
    logic en;

    assign en      = !m_valid || m_ready;
    assign s_ready = en && aresetn;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= hgcd_pkg::RADIUS_RESET;
            vld_reg    <= '0;
        end else begin
            if (cfg_we) begin
                radius_reg <= cfg_wdata;
            end
            if (en) begin
                vld_reg <= {vld_reg[LAT-2:0], s_valid};
            end
        end
    end

    // ---------------- stage 0: wrap and fold ----------------
    function automatic logic [UW-1:0] wrap_mag(input logic signed [31:0] d);
        logic signed [31:0] m;
        m = d;
        if (m >= 32'(hgcd_pkg::UDEG_HALF_TURN)) begin
            m = m - 32'(hgcd_pkg::UDEG_TURN);
        end else if (m < -32'(hgcd_pkg::UDEG_HALF_TURN)) begin
            m = m + 32'(hgcd_pkg::UDEG_TURN);
        end
        return UW'(m < 0 ? -m : m);
    endfunction

    // Latitude is within one turn either way of zero, one step suffices
    logic [UW-1:0] dlat_next, dlon_next, la_next, lb_next;
    logic          na_next, nb_next;
    logic [UW-1:0] dlat_reg, dlon_reg, la_reg, lb_reg;
    logic          na_reg, nb_reg;

    always_comb begin
        dlat_next = wrap_mag(32'(s_lat_b) - 32'(s_lat_a));
        dlon_next = wrap_mag(32'(s_lon_b) - 32'(s_lon_a));
        la_next   = wrap_mag(32'(s_lat_a));
        lb_next   = wrap_mag(32'(s_lat_b));
        na_next   = 32'(la_next) > 32'(hgcd_pkg::UDEG_QUARTER_TURN);
        nb_next   = 32'(lb_next) > 32'(hgcd_pkg::UDEG_QUARTER_TURN);
        if (na_next) la_next = UW'(32'(hgcd_pkg::UDEG_HALF_TURN) - 32'(la_next));
        if (nb_next) lb_next = UW'(32'(hgcd_pkg::UDEG_HALF_TURN) - 32'(lb_next));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dlat_reg <= dlat_next;
            dlon_reg <= dlon_next;
            la_reg   <= la_next;
            lb_reg   <= lb_next;
            na_reg   <= na_next;
            nb_reg   <= nb_next;
        end
    end

    // ---------------- stage 1: to radians ----------------
    function automatic logic signed [W-1:0] to_rad(input logic [UW-1:0] a, input int s);
        logic [127:0] p;
        p = 128'(a) * 128'(hgcd_pkg::RAD_PER_UDEG_Q62) + (128'd1 << (s - 1));
        return W'(p >> s);
    endfunction

    logic signed [W-1:0] th_reg [4];
    logic na1_reg, nb1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            th_reg[0] <= to_rad(dlat_reg, 63 - F);
            th_reg[1] <= to_rad(dlon_reg, 63 - F);
            th_reg[2] <= to_rad(la_reg, 62 - F);
            th_reg[3] <= to_rad(lb_reg, 62 - F);
            na1_reg   <= na_reg;
            nb1_reg   <= nb_reg;
        end
    end

    // ---------------- rotation chains ----------------
    logic signed [W-1:0] rx [4][N+1];
    logic signed [W-1:0] ry [4][N+1];
    logic signed [W-1:0] rz [4][N+1];
    logic [N-1:0] na_sh_reg, nb_sh_reg;

    for (genvar c = 0; c < 4; c++) begin : g_rot
        assign rx[c][0] = W'(hgcd_pkg::inv_gain(F));
        assign ry[c][0] = '0;
        assign rz[c][0] = th_reg[c];
        for (genvar i = 0; i < N; i++) begin : g_cell
            hgcd_rot_cell #(
                .W(W), .SHIFT(i), .ATAN(W'(hgcd_pkg::atan_entry(i, F)))
            ) u_cell (
                .aclk (aclk), .en(en),
                .x_in (rx[c][i]), .y_in(ry[c][i]), .z_in(rz[c][i]),
                .x_out(rx[c][i+1]), .y_out(ry[c][i+1]), .z_out(rz[c][i+1])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            na_sh_reg <= N > 1 ? {na_sh_reg[N-2:0], na1_reg} : N'(na1_reg);
            nb_sh_reg <= N > 1 ? {nb_sh_reg[N-2:0], nb1_reg} : N'(nb1_reg);
        end
    end

    // ---------------- products ----------------
    function automatic logic [PW-1:0] mulq(input logic [F+1:0] a, input logic [F+1:0] b);
        logic [2*F+3:0] p;
        p = (2*F+4)'(a) * (2*F+4)'(b) + ((2*F+4)'(1) << (F - 1));
        return PW'(p >> F);
    endfunction

    function automatic logic [F+1:0] absv(input logic signed [W-1:0] v);
        logic signed [W-1:0] m;
        m = v < 0 ? -v : v;
        return (F+2)'(m);
    endfunction

    logic [F+1:0] s1_reg, s2_reg, c1_reg, c2_reg;
    logic         neg_reg;
    logic [F+1:0] sq1_reg, sq2_reg, pc_reg, sq1b_reg;
    logic         neg2_reg, neg3_reg;
    logic [PW-1:0] p3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg   <= absv(ry[0][N]);
            s2_reg   <= absv(ry[1][N]);
            c1_reg   <= absv(rx[2][N]);
            c2_reg   <= absv(rx[3][N]);
            // cosine product is negative when exactly one folded cosine is negative (neither zero)
            neg_reg  <= ((rx[2][N] < 0) ^ na_sh_reg[N-1]) != ((rx[3][N] < 0) ^ nb_sh_reg[N-1])
                        && rx[2][N] != 0 && rx[3][N] != 0;
            sq1_reg  <= (F+2)'(mulq(s1_reg, s1_reg));
            sq2_reg  <= (F+2)'(mulq(s2_reg, s2_reg));
            pc_reg   <= (F+2)'(mulq(c1_reg, c2_reg));
            neg2_reg <= neg_reg;
            p3_reg   <= mulq(pc_reg, sq2_reg);
            sq1b_reg <= sq1_reg;
            neg3_reg <= neg2_reg;
        end
    end

    // ---------------- clamp ----------------
    logic signed [PW+1:0] h_sum;
    logic [F:0] h_reg;
    always_comb begin
        h_sum = neg3_reg ? ((PW+2)'(sq1b_reg) - (PW+2)'(p3_reg))
                         : ((PW+2)'(sq1b_reg) + (PW+2)'(p3_reg));
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            if (h_sum < 0) h_reg <= '0;
            else if (h_sum > (PW+2)'(1) << F) h_reg <= (F+1)'(1) << F;
            else h_reg <= (F+1)'(h_sum);
        end
    end

    // ---------------- square roots ----------------
    logic [STW-1:0] ta [SRW+1];
    logic [STW-1:0] tb [SRW+1];
    logic [SRW-1:0] ra [SRW+1];
    logic [SRW-1:0] rb [SRW+1];
    assign ta[0] = STW'(((F+1)'(1) << F) - h_reg) << F;
    assign tb[0] = STW'(h_reg) << F;
    assign ra[0] = '0;
    assign rb[0] = '0;
    for (genvar b = 0; b < SRW; b++) begin : g_sqrt
        hgcd_sqrt_cell #(.RW(SRW), .TW(STW), .BIT(F - b)) u_a (
            .aclk(aclk), .en(en), .t_in(ta[b]), .r_in(ra[b]),
            .t_out(ta[b+1]), .r_out(ra[b+1])
        );
        hgcd_sqrt_cell #(.RW(SRW), .TW(STW), .BIT(F - b)) u_b (
            .aclk(aclk), .en(en), .t_in(tb[b]), .r_in(rb[b]),
            .t_out(tb[b+1]), .r_out(rb[b+1])
        );
    end

    // ---------------- vectoring chain ----------------
    logic signed [W-1:0] vx [N+1];
    logic signed [W-1:0] vy [N+1];
    logic signed [W-1:0] vz [N+1];
    assign vx[0] = W'(ra[SRW]);
    assign vy[0] = W'(rb[SRW]);
    assign vz[0] = '0;
    for (genvar i = 0; i < N; i++) begin : g_vec
        hgcd_vec_cell #(
            .W(W), .SHIFT(i), .ATAN(W'(hgcd_pkg::atan_entry(i, F)))
        ) u_cell (
            .aclk (aclk), .en(en),
            .x_in (vx[i]), .y_in(vy[i]), .z_in(vz[i]),
            .x_out(vx[i+1]), .y_out(vy[i+1]), .z_out(vz[i+1])
        );
    end

    // ---------------- scale ----------------
    logic [W-1:0] z_reg;
    logic [hgcd_pkg::DIST_W-1:0] d_reg;
    logic [W+hgcd_pkg::RADIUS_W:0] dp;

    always_comb begin
        dp = ((W+hgcd_pkg::RADIUS_W+1)'(radius_reg) * (W+hgcd_pkg::RADIUS_W+1)'(z_reg)
              + ((W+hgcd_pkg::RADIUS_W+1)'(1) << (F - 1))) >> F;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg <= vz[N] < 0 ? '0 : W'({vz[N], 1'b0});
            d_reg <= dp > (W+hgcd_pkg::RADIUS_W+1)'(hgcd_pkg::DIST_MAX)
                     ? hgcd_pkg::DIST_W'(hgcd_pkg::DIST_MAX)
                     : hgcd_pkg::DIST_W'(dp);
        end
    end

    assign m_distance_m = d_reg;
endmodule

[src/hgcd_rot_cell.sv]
// One rotation-mode CORDIC step
module hgcd_rot_cell #(
    parameter int W     = 34,
    parameter int SHIFT = 0,
    parameter logic signed [W-1:0] ATAN = '0
) (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [W-1:0] x_in,
    input  logic signed [W-1:0] y_in,
    input  logic signed [W-1:0] z_in,
    output logic signed [W-1:0] x_out,
    output logic signed [W-1:0] y_out,
    output logic signed [W-1:0] z_out
);
    logic signed [W-1:0] x_reg, y_reg, z_reg;
    logic signed [W-1:0] x_next, y_next, z_next;
    logic signed [W-1:0] dx, dy;

    always_comb begin
        dx = y_in >>> SHIFT;
        dy = x_in >>> SHIFT;
        if (!z_in[W-1]) begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end else begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

[src/hgcd_vec_cell.sv]
// One vectoring-mode CORDIC step
module hgcd_vec_cell #(
    parameter int W     = 34,
    parameter int SHIFT = 0,
    parameter logic signed [W-1:0] ATAN = '0
) (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [W-1:0] x_in,
    input  logic signed [W-1:0] y_in,
    input  logic signed [W-1:0] z_in,
    output logic signed [W-1:0] x_out,
    output logic signed [W-1:0] y_out,
    output logic signed [W-1:0] z_out
);
    logic signed [W-1:0] x_reg, y_reg, z_reg;
    logic signed [W-1:0] x_next, y_next, z_next;
    logic signed [W-1:0] dx, dy;

    always_comb begin
        dx = y_in >>> SHIFT;
        dy = x_in >>> SHIFT;
        if (y_in > 0) begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end else begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

[src/hgcd_sqrt_cell.sv]
// One restoring square-root step: decides result bit BIT
module hgcd_sqrt_cell #(
    parameter int RW  = 31,
    parameter int TW  = 62,
    parameter int BIT = 0
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [TW-1:0] t_in,
    input  logic [RW-1:0] r_in,
    output logic [TW-1:0] t_out,
    output logic [RW-1:0] r_out
);
    logic [RW-1:0]   r_reg, r_next, cand;
    logic [TW-1:0]   t_reg;
    logic [2*RW-1:0] sq;

    always_comb begin
        cand   = r_in | (RW'(1) << BIT);
        sq     = (2*RW)'(cand) * (2*RW)'(cand);
        r_next = ((2*RW > TW ? sq : (2*RW)'(sq)) <= (2*RW)'(t_in)) ? cand : r_in;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg <= r_next;
            t_reg <= t_in;
        end
    end

    assign r_out = r_reg;
    assign t_out = t_reg;
endmodule

[verif/tb_haversine_great_circle_distance.sv]
module tb_haversine_great_circle_distance;

    localparam int FRAC   = hgcd_pkg::DEFAULT_FRAC_BITS;
    localparam int ITERS  = hgcd_pkg::DEFAULT_ITERATIONS;
    localparam int LATENCY = 2 + ITERS + 3 + 1 + FRAC + 1 + ITERS + 2;

    localparam int LAT_W    = hgcd_pkg::LAT_W;
    localparam int LON_W    = hgcd_pkg::LON_W;
    localparam int DIST_W   = hgcd_pkg::DIST_W;
    localparam int RADIUS_W = hgcd_pkg::RADIUS_W;

    localparam longint UDEG_TURN         = hgcd_pkg::UDEG_TURN;
    localparam longint UDEG_HALF_TURN    = hgcd_pkg::UDEG_HALF_TURN;
    localparam longint UDEG_QUARTER_TURN = hgcd_pkg::UDEG_QUARTER_TURN;

    localparam logic [63:0] RAD_PER_UDEG_Q62 = hgcd_pkg::RAD_PER_UDEG_Q62;
    localparam logic [63:0] INV_GAIN_Q62     = hgcd_pkg::INV_GAIN_Q62;
    localparam logic [63:0] QUARTER_PI_Q62   = hgcd_pkg::QUARTER_PI_Q62;
    localparam logic [63:0] DIST_MAX         = hgcd_pkg::DIST_MAX;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = hgcd_pkg::RADIUS_RESET;

    typedef struct {
        logic signed [LAT_W-1:0] lat_a;
        logic signed [LON_W-1:0] lon_a;
        logic signed [LAT_W-1:0] lat_b;
        logic signed [LON_W-1:0] lon_b;
    } position_pair_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [LAT_W-1:0]  s_lat_a = '0;
    logic signed [LON_W-1:0]  s_lon_a = '0;
    logic signed [LAT_W-1:0]  s_lat_b = '0;
    logic signed [LON_W-1:0]  s_lon_b = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [DIST_W-1:0]        m_distance_m;
    logic                     cfg_we = 1'b0;
    logic [RADIUS_W-1:0]      cfg_wdata = '0;

    longint                   arctan_q [ITERS];
    logic [RADIUS_W-1:0]      radius_m;
    logic [DIST_W-1:0]        expected_dist_q [$];
    int                       error_count = 0;
    int                       sent_count = 0;
    int                       checked_count = 0;
    bit                       quiet = 1'b0;

    haversine_great_circle_distance u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_lat_a      (s_lat_a),
        .s_lon_a      (s_lon_a),
        .s_lat_b      (s_lat_b),
        .s_lon_b      (s_lon_b),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_distance_m (m_distance_m),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // ---------------- distance predictor ----------------

    function automatic logic [63:0] round_q62(logic [63:0] v);
        return (v + (64'd1 << (61 - FRAC))) >> (62 - FRAC);
    endfunction

    // (a*b) >> sh, rounded half up
    function automatic logic [63:0] mul_round(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        p = p + (128'd1 << (sh - 1));
        return 64'(p >> sh);
    endfunction

    function automatic logic [63:0] magnitude(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic void load_arctan();
        logic [63:0] acc;
        logic [63:0] term;
        int          e;
        int          k;
        for (int i = 0; i < ITERS; i++) begin
            acc = 64'd0;
            if (i == 0) begin
                acc = QUARTER_PI_Q62;
            end else begin
                k = 0;
                for (e = i; e <= 62; e += 2 * i) begin
                    term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
                    acc = (k % 2 == 1) ? acc - term : acc + term;
                    k++;
                end
            end
            arctan_q[i] = longint'(round_q62(acc));
        end
    endfunction

    function automatic longint fold_turn(longint d);
        longint m;
        m = d % UDEG_TURN;
        if (m < 0) m += UDEG_TURN;
        if (m >= UDEG_HALF_TURN) m -= UDEG_TURN;
        return m;
    endfunction

    function automatic void rotate_to(longint theta, output longint c, output longint s);
        longint x, y, z, dx, dy;
        x = longint'(round_q62(INV_GAIN_Q62));
        y = 0;
        z = theta;
        for (int i = 0; i < ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_q[i];
            end else begin
                x += dx; y -= dy; z += arctan_q[i];
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic longint vector_to_angle(longint x, longint y);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += arctan_q[i];
            end else begin
                x -= dx; y += dy; z -= arctan_q[i];
            end
        end
        return z;
    endfunction

    function automatic logic [63:0] half_angle_sin(longint d);
        longint c, s;
        rotate_to(longint'(mul_round(magnitude(fold_turn(d)), RAD_PER_UDEG_Q62, 63 - FRAC)),
                  c, s);
        return magnitude(s);
    endfunction

    // latitudes past a pole fold back and flip the cosine
    function automatic longint latitude_cos(longint lat);
        longint      c, s;
        logic [63:0] a;
        bit          flip;
        a = magnitude(fold_turn(lat));
        flip = 1'b0;
        if (a > 64'(UDEG_QUARTER_TURN)) begin
            a = 64'(UDEG_HALF_TURN) - a;
            flip = 1'b1;
        end
        rotate_to(longint'(mul_round(a, RAD_PER_UDEG_Q62, 62 - FRAC)), c, s);
        return flip ? -c : c;
    endfunction

    function automatic logic [63:0] frac_sqrt(logic [63:0] v);
        logic [127:0] target;
        logic [63:0]  r, c;
        target = 128'(v) << FRAC;
        r = 64'd0;
        for (int b = FRAC; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= target) r = c;
        end
        return r;
    endfunction

    function automatic logic [DIST_W-1:0] great_circle_m(position_pair_t p);
        longint      la, oa, lb, ob, c1, c2, h, z, one;
        logic [63:0] s1, s2, sq1, prod, d;
        la = longint'(p.lat_a);
        oa = longint'(p.lon_a);
        lb = longint'(p.lat_b);
        ob = longint'(p.lon_b);
        one = longint'(1) << FRAC;
        s1 = half_angle_sin(lb - la);
        s2 = half_angle_sin(ob - oa);
        c1 = latitude_cos(la);
        c2 = latitude_cos(lb);
        sq1 = mul_round(s1, s1, FRAC);
        prod = mul_round(magnitude(c1), magnitude(c2), FRAC);
        prod = mul_round(prod, mul_round(s2, s2, FRAC), FRAC);
        if ((c1 < 0) != (c2 < 0)) h = longint'(sq1) - longint'(prod);
        else h = longint'(sq1) + longint'(prod);
        if (h < 0) h = 0;
        if (h > one) h = one;
        z = vector_to_angle(longint'(frac_sqrt(64'(one - h))), longint'(frac_sqrt(64'(h))));
        if (z < 0) z = 0;
        d = mul_round(64'(radius_m), 64'(2 * z), FRAC);
        if (d > DIST_MAX) d = DIST_MAX;
        return d[DIST_W-1:0];
    endfunction

    // ---------------- drivers and checker ----------------

    task automatic send_pair(position_pair_t p);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_lat_a <= p.lat_a;
        s_lon_a <= p.lon_a;
        s_lat_b <= p.lat_b;
        s_lon_b <= p.lon_b;
        do @(posedge aclk); while (!s_ready);
        expected_dist_q.push_back(great_circle_m(p));
        sent_count++;
    endtask

    task automatic send_coords(longint la, longint oa, longint lb, longint ob);
        position_pair_t p;
        p.lat_a = la[LAT_W-1:0];
        p.lon_a = oa[LON_W-1:0];
        p.lat_b = lb[LAT_W-1:0];
        p.lon_b = ob[LON_W-1:0];
        send_pair(p);
    endtask

    // hold off new requests until every expected distance is back
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_dist_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
    endtask

    task automatic write_radius(logic [RADIUS_W-1:0] r);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= r;
        @(posedge aclk);
        cfg_we <= 1'b0;
        radius_m = r;
    endtask

    function automatic longint rand_span(longint half);
        return longint'($urandom_range(32'(2 * half))) - half;
    endfunction

    function automatic position_pair_t random_pair();
        position_pair_t p;
        int             kind;
        longint         lon;
        kind = $urandom_range(0, 19);
        if (kind < 13) begin
            p.lat_a = LAT_W'(rand_span(UDEG_QUARTER_TURN));
            p.lon_a = LON_W'(rand_span(UDEG_HALF_TURN));
            p.lat_b = LAT_W'(rand_span(UDEG_QUARTER_TURN));
            p.lon_b = LON_W'(rand_span(UDEG_HALF_TURN));
        end else if (kind < 16) begin
            // full field range, including latitudes past the poles
            p.lat_a = LAT_W'($urandom());
            p.lon_a = LON_W'($urandom());
            p.lat_b = LAT_W'($urandom());
            p.lon_b = LON_W'($urandom());
        end else if (kind < 18) begin
            // nearby points
            p.lat_a = LAT_W'(rand_span(UDEG_QUARTER_TURN - 1000));
            p.lon_a = LON_W'(rand_span(UDEG_HALF_TURN));
            p.lat_b = LAT_W'(longint'(p.lat_a) + rand_span(1000));
            p.lon_b = LON_W'(longint'(p.lon_a) + rand_span(1000));
        end else begin
            // nearly antipodal points
            p.lat_a = LAT_W'(rand_span(UDEG_QUARTER_TURN - 1000));
            p.lon_a = LON_W'(rand_span(UDEG_HALF_TURN - 1000));
            p.lat_b = LAT_W'(rand_span(1000) - longint'(p.lat_a));
            lon = longint'(p.lon_a) + UDEG_HALF_TURN + rand_span(1000);
            if (lon > UDEG_HALF_TURN) lon -= UDEG_TURN;
            p.lon_b = LON_W'(lon);
        end
        return p;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_dist_q.size() == 0) begin
                $error("distance_m: unexpected result %0d", m_distance_m);
                error_count++;
            end else begin
                if (m_distance_m !== expected_dist_q[0]) begin
                    $error("distance_m expected %0d got %0d", expected_dist_q[0],
                           m_distance_m);
                    error_count++;
                end
                void'(expected_dist_q.pop_front());
                checked_count++;
            end
        end
    end

    // receiver stalls in bursts
    initial begin
        forever begin
            if (quiet || $urandom_range(0, 3) != 0) begin
                m_ready <= 1'b1;
                repeat (quiet ? 1 : $urandom_range(1, 20)) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_directed();
        send_coords(0, 0, 0, 0);
        send_coords(UDEG_QUARTER_TURN, 0, -UDEG_QUARTER_TURN, 0);
        send_coords(0, 0, 0, UDEG_HALF_TURN);
        send_coords(0, -UDEG_HALF_TURN, 0, UDEG_HALF_TURN);
        send_coords(0, -179999999, 0, 179999999);
        send_coords(45000000, 10000000, -45000000, -170000000);
        send_coords(UDEG_QUARTER_TURN, 12345, UDEG_QUARTER_TURN, -98765);
        send_coords(-UDEG_QUARTER_TURN, UDEG_HALF_TURN, UDEG_QUARTER_TURN, -UDEG_HALF_TURN);
        send_coords(134217727, 268435455, -134217728, -268435456);
        send_coords(-134217728, -268435456, 134217727, 268435455);
        send_coords(100000000, 0, 20000000, 0);
        send_coords(-170000000, 5000000, 30000000, 5000000);
        send_coords(51500000, -120000, 51500001, -120001);
        send_coords(1, 1, 0, 0);
        send_coords(30000000, 40000000, -30000000, -140000000);
        send_coords(30000001, 40000000, -30000000, -140000000);
        send_coords(0, 268435455, 0, -268435456);
        send_coords(134217727, 0, 134217727, 0);
    endtask

    task automatic test_radius_settings();
        logic [RADIUS_W-1:0] radii [4] = '{24'd1, 24'hFFFFFF, 24'd0, 24'd6378137};
        foreach (radii[r]) begin
            write_radius(radii[r]);
            send_coords(0, 0, 0, UDEG_HALF_TURN);
            send_coords(UDEG_QUARTER_TURN, 0, -UDEG_QUARTER_TURN, 0);
            send_coords(10000000, 20000000, 11000000, 21000000);
            for (int i = 0; i < 12; i++) send_pair(random_pair());
        end
    endtask

    task automatic test_random_stream(int count);
        for (int i = 0; i < count; i++) begin
            if (i == count / 3) drain();
            if (i == count / 2) write_radius(24'($urandom_range(1, 24'hFFFFFF)));
            if (i == count - 200) quiet = 1'b1;
            send_pair(random_pair());
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        int wait_cycles;
        load_arctan();
        radius_m = RADIUS_RESET;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_radius_settings();
        write_radius(RADIUS_RESET);
        test_random_stream(1500);
        wait_cycles = 0;
        while (expected_dist_q.size() != 0 && wait_cycles < 100000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (LATENCY + 8) @(posedge aclk);
        if (expected_dist_q.size() != 0) begin
            $error("distance_m: %0d expected results never arrived",
                   expected_dist_q.size());
            error_count++;
        end
        $display("Sent %0d position pairs, checked %0d distances; radii 0, 1, max, default",
                 sent_count, checked_count);
        $display("and random radius, with pole, antipode, wrap and out-of-range latitudes.");
        if (error_count == 0) begin
            $display("tb_haversine_great_circle_distance: clean");
        end else begin
            $display("tb_haversine_great_circle_distance: errors");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("tb_haversine_great_circle_distance: errors");
        $finish;
    end

endmodule

[sim.f]
src/hgcd_pkg.sv
src/hgcd_rot_cell.sv
src/hgcd_vec_cell.sv
src/hgcd_sqrt_cell.sv
src/haversine_great_circle_distance.sv
verif/tb_haversine_great_circle_distance.sv
